// ===== src/assert_macros.svh =====
// assertion macros used by the edf datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/edf_pkg.sv =====
// types and constants of the edf feasibility scheduler
package edf_pkg;

    localparam int MAX_JOBS_DEF = 64;
    localparam int PROC_W       = 16;
    localparam int TIME_W       = 22;
    localparam int WEIGHT_W     = 16;
    localparam int IDX_OUT_W    = 6;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_FETCH_I,
        ST_LATCH_I,
        ST_SCAN,
        ST_SCAN_DONE,
        ST_PLACE,
        ST_CHK_ORD,
        ST_CHK_ADR,
        ST_CHK_EVAL,
        ST_EMT_ORD,
        ST_EMT_ADR,
        ST_EMT_EVAL,
        ST_FAIL
    } t_state;

    typedef enum logic [1:0] {
        ADDR_I,
        ADDR_J,
        ADDR_ORD
    } t_addr_sel;

    typedef struct packed {
        logic      load;
        logic      rank_init;
        logic      latch_i;
        logic      scan;
        logic      place;
        logic      walk_init;
        logic      chk_step;
        logic      emit_step;
        logic      emit_fail;
        logic      clr_count;
        t_addr_sel addr_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic j_last;
        logic i_last;
        logic k_last;
        logic miss;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== src/edf_feasibility_scheduler.sv =====
// top level of the edf feasibility scheduler
// loading: one job per cycle, each transfer taken in the cycle it arrives
// run: each job is ranked by a scan over all n jobs (n jobs, one limit store read port)
// then each job passes the ord, adr and eval states in the deadline check and again in the result walk
// results leave through an output register; input stalls from last job to last result
// reset: synchronous active low, clears job count, state and result valid; stores hold
module edf_feasibility_scheduler #(
    parameter int MAX_JOBS = edf_pkg::MAX_JOBS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [edf_pkg::PROC_W-1:0]     i_processing_time,
    input  logic [edf_pkg::TIME_W-1:0]     i_due_date,
    input  logic [edf_pkg::TIME_W-1:0]     i_hard_deadline,
    input  logic [edf_pkg::WEIGHT_W-1:0]   i_job_weight,
    input  logic                           i_marked_early,
    input  logic                           i_last_job,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [edf_pkg::IDX_OUT_W-1:0]  o_job_index,
    output logic [edf_pkg::TIME_W-1:0]     o_completion_time,
    output logic                           o_is_early,
    output logic [edf_pkg::TIME_W-1:0]     o_weighted_early,
    output logic                           o_feasible,
    output logic                           o_last_result
);

    // command and status between sequencer and datapath
    edf_pkg::t_dp_cmd cmd;
    edf_pkg::t_dp_sts sts;

    // sequencer: load, rank each job by counting earlier-ordered jobs, check, emit
    edf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last_job (i_last_job),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // stores, stable rank sort, completion time walk and result register
    edf_datapath #(
        .MAX_JOBS (MAX_JOBS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_processing_time (i_processing_time),
        .i_due_date        (i_due_date),
        .i_hard_deadline   (i_hard_deadline),
        .i_job_weight      (i_job_weight),
        .i_marked_early    (i_marked_early),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_job_index       (o_job_index),
        .o_completion_time (o_completion_time),
        .o_is_early        (o_is_early),
        .o_weighted_early  (o_weighted_early),
        .o_feasible        (o_feasible),
        .o_last_result     (o_last_result)
    );

endmodule

// ===== src/edf_ctrl.sv =====
// controller state machine of the edf feasibility scheduler
module edf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_last_job,
    input  edf_pkg::t_dp_sts  i_sts,
    output edf_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall
);

    edf_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= edf_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.addr_sel = edf_pkg::ADDR_ORD;
        o_in_stall     = 1'b1;
        case (r_state)
            edf_pkg::ST_LOAD: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_job) begin
                        o_cmd.rank_init = 1'b1;
                        n_state         = edf_pkg::ST_FETCH_I;
                    end
                end
            end
            edf_pkg::ST_FETCH_I: begin
                o_cmd.addr_sel = edf_pkg::ADDR_I;
                n_state        = edf_pkg::ST_LATCH_I;
            end
            edf_pkg::ST_LATCH_I: begin
                o_cmd.latch_i = 1'b1;
                n_state       = edf_pkg::ST_SCAN;
            end
            edf_pkg::ST_SCAN: begin
                o_cmd.addr_sel = edf_pkg::ADDR_J;
                o_cmd.scan     = 1'b1;
                if (i_sts.j_last) begin
                    n_state = edf_pkg::ST_SCAN_DONE;
                end
            end
            edf_pkg::ST_SCAN_DONE: begin
                n_state = edf_pkg::ST_PLACE;
            end
            edf_pkg::ST_PLACE: begin
                o_cmd.place = 1'b1;
                if (i_sts.i_last) begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = edf_pkg::ST_CHK_ORD;
                end else begin
                    n_state = edf_pkg::ST_FETCH_I;
                end
            end
            edf_pkg::ST_CHK_ORD: begin
                n_state = edf_pkg::ST_CHK_ADR;
            end
            edf_pkg::ST_CHK_ADR: begin
                n_state = edf_pkg::ST_CHK_EVAL;
            end
            edf_pkg::ST_CHK_EVAL: begin
                if (i_sts.miss) begin
                    n_state = edf_pkg::ST_FAIL;
                end else if (i_sts.k_last) begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = edf_pkg::ST_EMT_ORD;
                end else begin
                    o_cmd.chk_step = 1'b1;
                    n_state        = edf_pkg::ST_CHK_ORD;
                end
            end
            edf_pkg::ST_EMT_ORD: begin
                n_state = edf_pkg::ST_EMT_ADR;
            end
            edf_pkg::ST_EMT_ADR: begin
                n_state = edf_pkg::ST_EMT_EVAL;
            end
            edf_pkg::ST_EMT_EVAL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_step = 1'b1;
                    if (i_sts.k_last) begin
                        o_cmd.clr_count = 1'b1;
                        n_state         = edf_pkg::ST_LOAD;
                    end else begin
                        n_state = edf_pkg::ST_EMT_ORD;
                    end
                end
            end
            edf_pkg::ST_FAIL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_fail = 1'b1;
                    o_cmd.clr_count = 1'b1;
                    n_state         = edf_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = edf_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

// ===== src/edf_datapath.sv =====
// job stores, ranking sort, schedule walk and result register
`include "assert_macros.svh"

module edf_datapath #(
    parameter int MAX_JOBS = edf_pkg::MAX_JOBS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  edf_pkg::t_dp_cmd               i_cmd,
    output edf_pkg::t_dp_sts               o_sts,
    input  logic [edf_pkg::PROC_W-1:0]     i_processing_time,
    input  logic [edf_pkg::TIME_W-1:0]     i_due_date,
    input  logic [edf_pkg::TIME_W-1:0]     i_hard_deadline,
    input  logic [edf_pkg::WEIGHT_W-1:0]   i_job_weight,
    input  logic                           i_marked_early,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic [edf_pkg::IDX_OUT_W-1:0]  o_job_index,
    output logic [edf_pkg::TIME_W-1:0]     o_completion_time,
    output logic                           o_is_early,
    output logic [edf_pkg::TIME_W-1:0]     o_weighted_early,
    output logic                           o_feasible,
    output logic                           o_last_result
);

    localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int SW = edf_pkg::PROC_W + CW;
    localparam int TW = edf_pkg::TIME_W;
    localparam logic [CW-1:0] FULL = CW'(MAX_JOBS);

    logic [edf_pkg::PROC_W-1:0]   mem_proc   [MAX_JOBS];
    logic [TW-1:0]                mem_due    [MAX_JOBS];
    logic [TW-1:0]                mem_limit  [MAX_JOBS];
    logic [edf_pkg::WEIGHT_W-1:0] mem_weight [MAX_JOBS];
    logic [IW-1:0]                mem_order  [MAX_JOBS];

    logic [edf_pkg::PROC_W-1:0]   r_proc_q;
    logic [TW-1:0]                r_due_q;
    logic [TW-1:0]                r_limit_q;
    logic [edf_pkg::WEIGHT_W-1:0] r_weight_q;
    logic [IW-1:0]                r_order_q;

    logic [CW-1:0] r_count;
    logic [IW-1:0] r_i, r_j, r_j_d, r_rank, r_k;
    logic          r_scan_vld;
    logic [TW-1:0] r_lim_i;
    logic [SW-1:0] r_time;
    logic [TW-1:0] r_obj;

    logic [IW-1:0] rd_addr;
    logic [SW-1:0] n_time;
    logic [TW:0]   obj_sum;
    logic [TW-1:0] n_obj;
    logic          early;
    logic          ranks_ahead;

    always_comb begin
        case (i_cmd.addr_sel)
            edf_pkg::ADDR_I: rd_addr = r_i;
            edf_pkg::ADDR_J: rd_addr = r_j;
            default:         rd_addr = r_order_q;
        endcase
    end

    // store writes on load, registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count != FULL)) begin
            mem_proc[r_count[IW-1:0]]   <= i_processing_time;
            mem_due[r_count[IW-1:0]]    <= i_due_date;
            mem_limit[r_count[IW-1:0]]  <= i_marked_early ? i_due_date : i_hard_deadline;
            mem_weight[r_count[IW-1:0]] <= i_job_weight;
        end
        r_proc_q   <= mem_proc[rd_addr];
        r_due_q    <= mem_due[rd_addr];
        r_limit_q  <= mem_limit[rd_addr];
        r_weight_q <= mem_weight[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.place) begin
            mem_order[r_rank] <= r_i;
        end
        r_order_q <= mem_order[r_k];
    end

    assign ranks_ahead = (r_limit_q < r_lim_i) || ((r_limit_q == r_lim_i) && (r_j_d < r_i));
    assign n_time = r_time + SW'(r_proc_q);
    assign early  = n_time <= SW'(r_due_q);
    assign obj_sum = {1'b0, r_obj} + (TW+1)'(r_weight_q);
    assign n_obj  = !early ? r_obj : (obj_sum[TW] ? edf_pkg::TIME_MAX : obj_sum[TW-1:0]);

    assign o_sts.j_last   = (CW'(r_j) + CW'(1)) == r_count;
    assign o_sts.i_last   = (CW'(r_i) + CW'(1)) == r_count;
    assign o_sts.k_last   = (CW'(r_k) + CW'(1)) == r_count;
    assign o_sts.miss     = n_time > SW'(r_limit_q);
    assign o_sts.out_free = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_scan_vld <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_count) begin
                r_count <= '0;
            end else if (i_cmd.load && (r_count != FULL)) begin
                r_count <= r_count + CW'(1);
            end
            r_scan_vld <= i_cmd.scan;
            if (i_cmd.emit_step || i_cmd.emit_fail) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rank_init) begin
            r_i <= '0;
        end else if (i_cmd.place) begin
            r_i <= r_i + IW'(1);
        end
        if (i_cmd.latch_i) begin
            r_lim_i <= r_limit_q;
            r_j     <= '0;
            r_rank  <= '0;
        end else begin
            if (i_cmd.scan) begin
                r_j <= r_j + IW'(1);
            end
            if (r_scan_vld && ranks_ahead) begin
                r_rank <= r_rank + IW'(1);
            end
        end
        r_j_d <= r_j;
        if (i_cmd.walk_init) begin
            r_k    <= '0;
            r_time <= '0;
            r_obj  <= '0;
        end else if (i_cmd.chk_step || i_cmd.emit_step) begin
            r_k    <= r_k + IW'(1);
            r_time <= n_time;
            r_obj  <= n_obj;
        end
        if (i_cmd.emit_step) begin
            o_job_index       <= edf_pkg::IDX_OUT_W'(r_order_q);
            o_completion_time <= n_time[TW-1:0];
            o_is_early        <= early;
            o_weighted_early  <= o_sts.k_last ? n_obj : '0;
            o_feasible        <= 1'b1;
            o_last_result     <= o_sts.k_last;
        end else if (i_cmd.emit_fail) begin
            o_job_index       <= '0;
            o_completion_time <= '0;
            o_is_early        <= 1'b0;
            o_weighted_early  <= '0;
            o_feasible        <= 1'b0;
            o_last_result     <= 1'b1;
        end
    end

    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= FULL, "job count past capacity")
    `ASSERT_IMPLIES(a_fail_alone, i_clk, i_rst_n, o_out_valid && !o_feasible, o_last_result && (o_completion_time == '0), "infeasible result malformed")
    `ASSERT_IMPLIES(a_obj_on_last, i_clk, i_rst_n, o_out_valid && (o_weighted_early != '0), o_last_result, "objective on non-final result")

endmodule

// ===== tb/tb.sv =====
// self-checking testbench of the edf feasibility scheduler
`timescale 1ns / 100ps

module tb;

    localparam int JOB_SLOTS = edf_pkg::MAX_JOBS_DEF;

    typedef struct packed {
        logic [edf_pkg::PROC_W-1:0]   proc_time;
        logic [edf_pkg::TIME_W-1:0]   due;
        logic [edf_pkg::TIME_W-1:0]   deadline;
        logic [edf_pkg::WEIGHT_W-1:0] weight;
        logic                         mark;
        logic                         last;
    } t_job;

    typedef struct packed {
        logic [edf_pkg::IDX_OUT_W-1:0] index;
        logic [edf_pkg::TIME_W-1:0]    finish;
        logic                          early;
        logic [edf_pkg::TIME_W-1:0]    objective;
        logic                          feasible;
        logic                          last;
    } t_slot;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    logic [edf_pkg::PROC_W-1:0]    i_processing_time;
    logic [edf_pkg::TIME_W-1:0]    i_due_date;
    logic [edf_pkg::TIME_W-1:0]    i_hard_deadline;
    logic [edf_pkg::WEIGHT_W-1:0]  i_job_weight;
    logic                          i_marked_early;
    logic                          i_last_job;
    logic o_out_valid;
    logic i_out_stall;
    logic [edf_pkg::IDX_OUT_W-1:0] o_job_index;
    logic [edf_pkg::TIME_W-1:0]    o_completion_time;
    logic                          o_is_early;
    logic [edf_pkg::TIME_W-1:0]    o_weighted_early;
    logic                          o_feasible;
    logic                          o_last_result;

    // stimulus and expected schedule slots
    t_job  job_q[$];
    t_slot slot_q[$];

    // predictor copy of the job stores
    logic [edf_pkg::PROC_W-1:0]   pr_proc[JOB_SLOTS];
    logic [edf_pkg::TIME_W-1:0]   pr_due[JOB_SLOTS];
    logic [edf_pkg::TIME_W-1:0]   pr_limit[JOB_SLOTS];
    logic [edf_pkg::WEIGHT_W-1:0] pr_weight[JOB_SLOTS];
    int                           pr_count;

    int   errors;
    int   n_jobs_taken;
    int   n_runs;
    int   n_infeasible;
    int   n_slots_checked;
    bit   taken;
    bit   calm;
    bit   long_hold_req;
    int   send_gap;
    int   hold_cnt;

    edf_feasibility_scheduler u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 15);
        if (calm || r < 9) return 0;
        if (r < 14) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d (slot %0d)", what, got, want,
                 n_slots_checked);
        errors++;
    endtask

    // store one job; a last job runs the edf order, the deadline check and the walk
    task automatic schedule_job(input t_job j);
        int    order[JOB_SLOTS];
        int    n, k, cur;
        logic [63:0] t_acc;
        logic [63:0] obj_acc;
        bit    ok;
        t_slot s;
        if (pr_count < JOB_SLOTS) begin
            pr_proc[pr_count]   = j.proc_time;
            pr_due[pr_count]    = j.due;
            pr_limit[pr_count]  = j.mark ? j.due : j.deadline;
            pr_weight[pr_count] = j.weight;
            pr_count++;
        end
        if (!j.last) return;
        n = pr_count;
        // stable insertion sort on effective deadline
        for (int i = 0; i < n; i++) begin
            cur = i;
            k = i;
            while (k > 0 && pr_limit[order[k-1]] > pr_limit[cur]) begin
                order[k] = order[k-1];
                k--;
            end
            order[k] = cur;
        end
        t_acc = 0;
        ok = 1'b1;
        for (int i = 0; i < n; i++) begin
            t_acc += pr_proc[order[i]];
            if (t_acc > pr_limit[order[i]]) ok = 1'b0;
        end
        n_runs++;
        if (!ok) begin
            s = '0;
            s.last = 1'b1;
            slot_q = {slot_q, s};
            n_infeasible++;
        end else begin
            t_acc = 0;
            obj_acc = 0;
            for (int i = 0; i < n; i++) begin
                t_acc += pr_proc[order[i]];
                s.index    = order[i][edf_pkg::IDX_OUT_W-1:0];
                s.finish   = t_acc[edf_pkg::TIME_W-1:0];
                s.early    = (t_acc <= pr_due[order[i]]);
                if (s.early) begin
                    obj_acc += pr_weight[order[i]];
                    if (obj_acc > edf_pkg::TIME_MAX) obj_acc = edf_pkg::TIME_MAX;
                end
                s.last      = (i == n - 1);
                s.objective = s.last ? obj_acc[edf_pkg::TIME_W-1:0] : '0;
                s.feasible  = 1'b1;
                slot_q = {slot_q, s};
            end
        end
        pr_count = 0;
    endtask

    // acceptance and result checking at the rising edge
    always @(posedge i_clk) begin
        t_slot w;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                schedule_job({i_processing_time, i_due_date, i_hard_deadline,
                              i_job_weight, i_marked_early, i_last_job});
                n_jobs_taken++;
                taken = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (slot_q.size() == 0) begin
                    report_mismatch("unexpected result, job_index", o_job_index, 0);
                end else begin
                    w = slot_q.pop_front();
                    if (o_job_index !== w.index)
                        report_mismatch("job_index", o_job_index, w.index);
                    if (o_completion_time !== w.finish)
                        report_mismatch("completion_time", o_completion_time, w.finish);
                    if (o_is_early !== w.early)
                        report_mismatch("is_early", o_is_early, w.early);
                    if (o_weighted_early !== w.objective)
                        report_mismatch("weighted_early", o_weighted_early, w.objective);
                    if (o_feasible !== w.feasible)
                        report_mismatch("feasible", o_feasible, w.feasible);
                    if (o_last_result !== w.last)
                        report_mismatch("last_result", o_last_result, w.last);
                    n_slots_checked++;
                end
            end
        end
    end

    // job driver, fed from the queue at the falling edge
    always @(negedge i_clk) begin
        t_job j;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || taken) begin
            taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (job_q.size() > 0) begin
                j = job_q.pop_front();
                i_processing_time <= j.proc_time;
                i_due_date        <= j.due;
                i_hard_deadline   <= j.deadline;
                i_job_weight      <= j.weight;
                i_marked_early    <= j.mark;
                i_last_job        <= j.last;
                i_in_valid        <= 1'b1;
                send_gap = pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver stall, with one long hold on request
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            hold_cnt = 600;
            long_hold_req = 1'b0;
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_stall <= 1'b1;
        end else begin
            hold_cnt = pick_gap();
            i_out_stall <= (hold_cnt != 0);
        end
    end

    task automatic add_job(input int p, input int d, input int dl, input int wt,
                           input bit mk, input bit lst);
        t_job j;
        j.proc_time = p;
        j.due       = d;
        j.deadline  = dl;
        j.weight    = wt;
        j.mark      = mk;
        j.last      = lst;
        job_q = {job_q, j};
    endtask

    // one random set; most are well formed and feasible, the rest is noise
    task automatic add_random_set(input int n);
        int  kind;
        int  span;
        bit  mk;
        kind = $urandom_range(0, 9);
        span = n * 2000;
        for (int i = 0; i < n; i++) begin
            if (kind < 7) begin
                mk = ($urandom_range(0, 3) == 0);
                add_job($urandom_range(0, 2000),
                        mk ? $urandom_range(span, edf_pkg::TIME_MAX)
                           : $urandom_range(0, span),
                        $urandom_range(span, edf_pkg::TIME_MAX), $urandom_range(0, 65535),
                        mk, i == n - 1);
            end else begin
                add_job($urandom_range(0, 65535), $urandom_range(0, edf_pkg::TIME_MAX),
                        $urandom_range(0, edf_pkg::TIME_MAX), $urandom_range(0, 65535),
                        $urandom_range(0, 1), i == n - 1);
            end
        end
    endtask

    task automatic wait_drained();
        while (job_q.size() > 0 || i_in_valid || slot_q.size() > 0) @(posedge i_clk);
    endtask

    function automatic int pick_size();
        if ($urandom_range(0, 9) == 0) return $urandom_range(16, 64);
        return $urandom_range(1, 8);
    endfunction

    initial begin
        int sent;
        errors = 0; n_jobs_taken = 0; n_runs = 0; n_infeasible = 0;
        n_slots_checked = 0; pr_count = 0; taken = 1'b0; calm = 1'b0;
        long_hold_req = 1'b0; send_gap = 0; hold_cnt = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_processing_time = '0; i_due_date = '0; i_hard_deadline = '0;
        i_job_weight = '0; i_marked_early = 1'b0; i_last_job = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // single job at all-zero fields, then at the top of every field
        add_job(0, 0, 0, 0, 0, 1);
        add_job(65535, edf_pkg::TIME_MAX, edf_pkg::TIME_MAX, 65535, 1, 1);
        // lone job missing its hard deadline
        add_job(100, 500, 50, 7, 0, 1);
        // marked job missing its due date though its deadline is loose
        add_job(10, 5, 1000, 3, 0, 0);
        add_job(20, 15, edf_pkg::TIME_MAX, 3, 1, 1);
        // equal effective deadlines keep load order; the set misses a deadline
        add_job(30, 10, 100, 5, 0, 0);
        add_job(40, 100, 900, 6, 1, 0);
        add_job(50, 200, 100, 7, 0, 0);
        add_job(20, 120, 100, 9, 0, 0);
        add_job(0, 0, 50, 11, 0, 1);
        // completion exactly on deadline and due date
        add_job(60, 60, 60, 1, 0, 0);
        add_job(40, 100, 100, 2, 1, 1);
        // weights at full scale in a feasible set
        for (int i = 0; i < 6; i++)
            add_job(1000, edf_pkg::TIME_MAX, edf_pkg::TIME_MAX, 65535, i[0], i == 5);
        wait_drained();

        // long receiver hold while sets keep coming
        long_hold_req = 1'b1;
        sent = 0;
        while (sent < 25) begin
            int n;
            n = pick_size();
            add_random_set(n);
            sent += n;
        end
        // sender waits for every result before going on
        wait_drained();
        calm = 1'b1;
        while (sent < 45) begin
            int n;
            n = $urandom_range(1, 8);
            add_random_set(n);
            sent += n;
        end
        wait_drained();
        calm = 1'b0;
        while (sent < 75) begin
            int n;
            n = pick_size();
            add_random_set(n);
            sent += n;
        end
        // overfull set: the last two jobs are dropped, the final mark still runs it
        for (int i = 0; i < JOB_SLOTS + 2; i++)
            add_job($urandom_range(0, 1000), $urandom_range(0, 70000),
                    $urandom_range(70000, edf_pkg::TIME_MAX), $urandom_range(0, 65535),
                    1'b0, i == JOB_SLOTS + 1);
        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("covered %0d jobs in %0d runs (%0d infeasible), %0d results checked",
                 n_jobs_taken, n_runs, n_infeasible, n_slots_checked);
        $display("stalls long and short on both sides, an overfull store and extremes");
        if (errors == 0 && slot_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
